### sv/lsco_pkg.sv
// ----------------------------------------------------------------------------
// lsco_pkg
// shared types, constants and codes of the true-lru slot cache
// ----------------------------------------------------------------------------
package lsco_pkg;

  localparam int CACHE_SLOTS = 8;
  localparam int KEY_BITS    = 32;
  localparam int SLOT_W      = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int RANK_W      = SLOT_W;

  localparam logic [RANK_W-1:0] LRU_RANK = RANK_W'(CACHE_SLOTS - 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ACCESS = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // how a cell decides it is the one picked this cycle
  localparam logic [1:0] PICK_LRU   = 2'd0;
  localparam logic [1:0] PICK_SLOT  = 2'd1;
  localparam logic [1:0] PICK_FIRST = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] node_key;
    logic [2:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  used_slot;
    logic        hit;
    logic        released_valid;
    logic [31:0] released_key;
    logic        last;
  } out_item_t;

  // selection broadcast to every cell
  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
  } cell_sel_t;

  // update broadcast to every cell, acted on by the picked cell or by all
  typedef struct packed {
    logic                write_en;
    logic                clear_en;
    logic                promote_en;
    logic [RANK_W-1:0]   old_rank;
    logic [KEY_BITS-1:0] wkey;
  } cell_upd_t;

  // data handed from cell to cell along the row
  typedef struct packed {
    logic                taken;
    logic                valid;
    logic [KEY_BITS-1:0] key;
    logic [RANK_W-1:0]   rank;
    logic [SLOT_W-1:0]   idx;
  } chain_t;

endpackage

### sv/lru_slot_cache_order_core.sv
// ----------------------------------------------------------------------------
// lru_slot_cache_order_core
// true-lru slot cache of node keys built as a row of slot cells
// ----------------------------------------------------------------------------
// insert and access: the request is registered when start is taken in idle, then
//   one pass along the cell row registers the result; flush releases one key per
//   cycle from the row's first-valid pick; no new start is taken while busy
// reset: synchronous active-low rst_n empties all slots, slot i gets rank i
// results are strobed on out_valid for one cycle; the receiver cannot stall
module lru_slot_cache_order_core import lsco_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  // control states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  in_item_t   req_r, req_nxt;
  logic       first_r, first_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  cell_sel_t  sel;
  cell_upd_t  upd;
  chain_t     link [CACHE_SLOTS+1];
  logic [CACHE_SLOTS-1:0] pick_vec;
  logic [CACHE_SLOTS-1:0] valid_vec;

  logic [KEY_BITS-1:0] req_key;
  logic                slot_ok;
  logic                hit;
  logic                flush_last;

  // row of slot cells, the pick data runs from slot 0 upward
  assign link[0] = '0;

  for (genvar i = 0; i < CACHE_SLOTS; i++) begin : g_cell
    lsco_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (SLOT_W'(i)),
      .sel       (sel),
      .upd       (upd),
      .chain_in  (link[i]),
      .chain_out (link[i+1]),
      .pick      (pick_vec[i]),
      .valid     (valid_vec[i])
    );
  end

  assign req_key = KEY_BITS'(req_r.node_key);
  assign slot_ok = (int'(req_r.slot) < CACHE_SLOTS);

  // access hits only on a valid slot in range holding the same key
  assign hit = slot_ok & link[CACHE_SLOTS].valid & (link[CACHE_SLOTS].key == req_key);

  // the picked slot is the final one when no other slot stays valid
  assign flush_last = ((valid_vec & ~pick_vec) == '0);

  // selection depends on the state and the registered request only
  always_comb begin
    sel.slot = SLOT_W'(req_r.slot);
    sel.mode = PICK_LRU;
    if (state_r == ST_FLUSH) begin
      sel.mode = PICK_FIRST;
    end else if (state_r == ST_EXEC && req_r.cmd == CMD_ACCESS) begin
      sel.mode = PICK_SLOT;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    first_nxt     = first_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    upd.write_en   = 1'b0;
    upd.clear_en   = 1'b0;
    upd.promote_en = 1'b0;
    upd.old_rank   = link[CACHE_SLOTS].rank;
    upd.wkey       = req_key;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_item;
          first_nxt = 1'b1;
          case (in_item.cmd)
            CMD_INSERT: state_nxt = ST_EXEC;
            CMD_ACCESS: state_nxt = ST_EXEC;
            CMD_FLUSH:  state_nxt = ST_FLUSH;
            default:    state_nxt = ST_IDLE;   // unused code is dropped
          endcase
        end
      end

      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        out_item_nxt.last = 1'b1;
        if (req_r.cmd == CMD_INSERT) begin
          // least recent slot takes the new key and becomes most recent
          upd.write_en   = 1'b1;
          upd.promote_en = 1'b1;
          out_item_nxt.used_slot      = 3'(link[CACHE_SLOTS].idx);
          out_item_nxt.hit            = 1'b0;
          out_item_nxt.released_valid = link[CACHE_SLOTS].valid;
          out_item_nxt.released_key   = link[CACHE_SLOTS].valid ?
                                        32'(link[CACHE_SLOTS].key) : 32'd0;
        end else begin
          upd.promote_en = hit;
          out_item_nxt.used_slot      = req_r.slot;
          out_item_nxt.hit            = hit;
          out_item_nxt.released_valid = 1'b0;
          out_item_nxt.released_key   = 32'd0;
        end
        state_nxt = ST_IDLE;
      end

      ST_FLUSH: begin
        first_nxt = 1'b0;
        if (link[CACHE_SLOTS].taken) begin
          // release the lowest valid slot this cycle
          upd.clear_en  = 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt.used_slot      = 3'(link[CACHE_SLOTS].idx);
          out_item_nxt.hit            = 1'b0;
          out_item_nxt.released_valid = 1'b1;
          out_item_nxt.released_key   = 32'(link[CACHE_SLOTS].key);
          out_item_nxt.last           = flush_last;
          if (flush_last) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          // nothing valid: a single empty result
          if (first_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '0;
            out_item_nxt.last = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### sv/lsco_cell.sv
// ----------------------------------------------------------------------------
// lsco_cell
// one cache slot: key, valid bit and lru rank, with a link to its neighbors
// ----------------------------------------------------------------------------
module lsco_cell import lsco_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  cell_sel_t         sel,
  input  cell_upd_t         upd,
  input  chain_t            chain_in,
  output chain_t            chain_out,
  output logic              pick,
  output logic              valid
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic                valid_r, valid_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;

  always_comb begin
    case (sel.mode)
      PICK_LRU:   pick = (rank_r == LRU_RANK);
      PICK_SLOT:  pick = (cell_idx == sel.slot);
      PICK_FIRST: pick = valid_r & ~chain_in.taken;
      default:    pick = 1'b0;
    endcase
  end

  // picked cell merges its content into the passing data
  always_comb begin
    chain_out.taken = chain_in.taken | pick;
    chain_out.valid = chain_in.valid | (pick & valid_r);
    chain_out.key   = chain_in.key  | (pick ? key_r    : '0);
    chain_out.rank  = chain_in.rank | (pick ? rank_r   : '0);
    chain_out.idx   = chain_in.idx  | (pick ? cell_idx : '0);
  end

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (pick && upd.write_en) begin
      key_nxt   = upd.wkey;
      valid_nxt = 1'b1;
    end
    if (pick && upd.clear_en) begin
      valid_nxt = 1'b0;
    end
    if (upd.promote_en) begin
      if (pick) begin
        rank_nxt = '0;
      end else if (rank_r < upd.old_rank) begin
        rank_nxt = rank_r + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= cell_idx;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign valid = valid_r;

endmodule
